// ===== sv/pidpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidpi_pkg
// Shared constants for the positional / incremental PID controller.
// ----------------------------------------------------------------------------
package pidpi_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned FracBitsDef    = 16;

  localparam int unsigned GainW   = 24;
  localparam int unsigned LimW    = 31;
  localparam int unsigned DriveW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 32;

  localparam logic [CfgIdxW-1:0] RegMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKp   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKi   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKd   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegOlim = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIlim = 3'd5;

  localparam logic ModePositional  = 1'b0;
  localparam logic ModeIncremental = 1'b1;

endpackage

// ===== sv/pid_position_and_incremental.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_and_incremental
// PID controller in positional or incremental form, fixed point gains.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_axis    in         tvalid / tready        measured, setpoint; tuser clear
//  m_axis    out        tvalid / tready        drive
//  cfg       in         cfg_valid / cfg_ready  register index, write data
//
//  One request per cycle unless the result stalls; input and result stages are registered.
//  The error history, integral and last drive close a loop through the
//  three gain multipliers and clamps inside the result stage.
//  Reset clears the valid flags, mode, gains, limits and controller state to zero.
//  A stalled result holds the input stage; the config port never stalls.
// ----------------------------------------------------------------------------
module pid_position_and_incremental #(
  parameter int unsigned SAMPLE_WIDTH = pidpi_pkg::SampleWidthDef,
  parameter int unsigned FRAC_BITS    = pidpi_pkg::FracBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  // measured, setpoint, zero padding
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
  // clear
  input  logic                                    s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  // drive
  output logic [pidpi_pkg::DriveW-1:0]            m_axis_tdata,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [pidpi_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [pidpi_pkg::CfgDatW-1:0]           cfg_data_i
);

  localparam int unsigned EW     = SAMPLE_WIDTH + 1;
  localparam int unsigned OpW    = SAMPLE_WIDTH + 3;
  localparam int unsigned ProdW  = pidpi_pkg::GainW + OpW;
  localparam int unsigned AccW   = ProdW + 3;
  localparam int unsigned GainW  = pidpi_pkg::GainW;
  localparam int unsigned LimW   = pidpi_pkg::LimW;
  localparam int unsigned DriveW = pidpi_pkg::DriveW;

  // configuration
  logic                    mode_q;
  logic signed [GainW-1:0] kp_q, ki_q, kd_q;
  logic [LimW-1:0]         olim_q, ilim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      olim_q <= '0;
      ilim_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pidpi_pkg::RegMode: mode_q <= cfg_data_i[0];
        pidpi_pkg::RegKp:   kp_q   <= cfg_data_i[GainW-1:0];
        pidpi_pkg::RegKi:   ki_q   <= cfg_data_i[GainW-1:0];
        pidpi_pkg::RegKd:   kd_q   <= cfg_data_i[GainW-1:0];
        pidpi_pkg::RegOlim: olim_q <= cfg_data_i[LimW-1:0];
        pidpi_pkg::RegIlim: ilim_q <= cfg_data_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                           s1_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_meas_q, s1_set_q;
  logic                           s1_clear_q;
  logic                           adv;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_meas_q  <= s_axis_tdata[SAMPLE_WIDTH-1:0];
      s1_set_q   <= s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      s1_clear_q <= s_axis_tuser;
    end
  end

  // controller state
  logic signed [EW-1:0]     err1_q, err2_q;
  logic signed [DriveW-1:0] integ_q, last_q;

  function automatic logic signed [AccW-1:0] clamp_f(input logic signed [AccW-1:0] x,
                                                     input logic [LimW-1:0] lim);
    logic signed [AccW-1:0] l;
    l = $signed({{(AccW-LimW){1'b0}}, lim});
    if (x > l)       return l;
    else if (x < -l) return -l;
    else             return x;
  endfunction

  logic signed [EW-1:0]     e;
  logic signed [OpW-1:0]    d1, d2, op_p, op_i, op_d;
  logic signed [ProdW-1:0]  prod_p, prod_i, prod_d;
  logic signed [AccW-1:0]   pp, pi, pd, isum, integ_c, drive_raw, drive_c;
  logic signed [DriveW-1:0] integ_d, drive_d;
  logic signed [EW-1:0]     err1_d, err2_d;

  always_comb begin
    e  = EW'(s1_set_q) - EW'(s1_meas_q);
    d1 = OpW'(e) - OpW'(err1_q);
    d2 = OpW'(e) - OpW'(err1_q) - OpW'(err1_q) + OpW'(err2_q);

    op_i = OpW'(e);
    op_p = (mode_q == pidpi_pkg::ModeIncremental) ? d1 : OpW'(e);
    op_d = (mode_q == pidpi_pkg::ModeIncremental) ? d2 : d1;

    prod_p = ProdW'(kp_q) * ProdW'(op_p);
    prod_i = ProdW'(ki_q) * ProdW'(op_i);
    prod_d = ProdW'(kd_q) * ProdW'(op_d);

    pp = AccW'(prod_p >>> FRAC_BITS);
    pi = AccW'(prod_i >>> FRAC_BITS);
    pd = AccW'(prod_d >>> FRAC_BITS);

    isum    = AccW'(integ_q) + pi;
    integ_c = clamp_f(isum, ilim_q);

    if (mode_q == pidpi_pkg::ModeIncremental) begin
      drive_raw = AccW'(last_q) + pp + pi + pd;
      integ_d   = pi[DriveW-1:0];
    end else begin
      drive_raw = pp + integ_c + pd;
      integ_d   = integ_c[DriveW-1:0];
    end
    drive_c = clamp_f(drive_raw, olim_q);
    drive_d = drive_c[DriveW-1:0];
    err1_d  = e;
    err2_d  = err1_q;

    if (s1_clear_q) begin
      integ_d = '0;
      drive_d = '0;
      err1_d  = '0;
      err2_d  = '0;
    end
  end

  logic                     m_valid_q;
  logic signed [DriveW-1:0] m_drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err1_q    <= '0;
      err2_q    <= '0;
      integ_q   <= '0;
      last_q    <= '0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        err1_q  <= err1_d;
        err2_q  <= err2_d;
        integ_q <= integ_d;
        last_q  <= drive_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      m_drive_q <= drive_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_drive_q;

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && s1_clear_q) |=> (m_axis_tdata == '0 && integ_q == '0))
    else $error("clear did not zero drive and integral");

  a_last_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=> (last_q == m_drive_q))
    else $error("last drive differs from issued drive");

  a_drive_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q) |=>
      (AccW'(m_drive_q) <= $signed({{(AccW-LimW){1'b0}}, $past(olim_q)}) &&
       AccW'(m_drive_q) >= -$signed({{(AccW-LimW){1'b0}}, $past(olim_q)})))
    else $error("drive outside output limit");

  a_integ_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s1_valid_q && mode_q == pidpi_pkg::ModePositional) |=>
      (AccW'(integ_q) <= $signed({{(AccW-LimW){1'b0}}, $past(ilim_q)}) &&
       AccW'(integ_q) >= -$signed({{(AccW-LimW){1'b0}}, $past(ilim_q)})))
    else $error("integral outside limit");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pid_position_and_incremental. A behavioural
// controller model predicts the drive value of every accepted request;
// results are compared in order. Covers register writes, both forms, clear
// requests, limits at their extremes, random traffic under stalls and a long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SampleW    = pidpi_pkg::SampleWidthDef;
  localparam int unsigned FracBits   = pidpi_pkg::FracBitsDef;
  localparam int unsigned GainW      = pidpi_pkg::GainW;
  localparam int unsigned LimW       = pidpi_pkg::LimW;
  localparam int unsigned DriveW     = pidpi_pkg::DriveW;
  localparam int unsigned CfgIdxW    = pidpi_pkg::CfgIdxW;
  localparam int unsigned CfgDatW    = pidpi_pkg::CfgDatW;
  localparam int unsigned DataW      = ((2 * SampleW + 7) / 8) * 8;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxReports = 10;

  localparam logic [CfgIdxW-1:0] RegSpare0 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare1 = 3'd7;

  localparam logic [GainW-1:0] GainMax = 24'h7FFFFF;
  localparam logic [GainW-1:0] GainMin = 24'h800000;
  localparam logic [LimW-1:0]  LimMax  = 31'h7FFFFFFF;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [DataW-1:0]       s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DriveW-1:0]      m_axis_tdata;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i = '0;
  logic [CfgDatW-1:0]     cfg_data_i = '0;

  // controller model: registers and loop state
  logic                   mode_r;
  logic signed [GainW-1:0] kp_r, ki_r, kd_r;
  logic [LimW-1:0]        out_lim_r, int_lim_r;
  longint                 err_last, err_older, integ_acc, drive_last;

  logic [DriveW-1:0]      drive_expected_q[$];
  logic [DriveW-1:0]      drive_want;
  int unsigned            mismatch_count = 0;
  int unsigned            cycle_count = 0;
  int unsigned            snd_idle_pct = 0;
  int unsigned            rcv_idle_pct = 0;
  int unsigned            hold_req = 0;
  int unsigned            hold_left = 0;

  pid_position_and_incremental uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("pid_position_and_incremental regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  function automatic longint scaled(input logic signed [GainW-1:0] g, input longint v);
    longint gl;
    gl = g;
    return (gl * v) >>> FracBits;
  endfunction

  function automatic longint clamp_sym(input longint x, input logic [LimW-1:0] lim);
    longint l;
    l = lim;
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

  function automatic logic [DriveW-1:0] predict_drive(input logic signed [SampleW-1:0] meas,
                                                      input logic signed [SampleW-1:0] sp,
                                                      input logic clr);
    longint e, e1, e2, it, acc;
    if (clr) begin
      err_last   = 0;
      err_older  = 0;
      integ_acc  = 0;
      drive_last = 0;
      return '0;
    end
    e  = longint'(sp) - longint'(meas);
    e1 = err_last;
    e2 = err_older;
    err_older = e1;
    err_last  = e;
    if (mode_r == pidpi_pkg::ModePositional) begin
      integ_acc = clamp_sym(integ_acc + scaled(ki_r, e), int_lim_r);
      acc = scaled(kp_r, e) + integ_acc + scaled(kd_r, e - e1);
    end else begin
      it = scaled(ki_r, e);
      integ_acc = $signed(it[31:0]);
      acc = drive_last + scaled(kp_r, e - e1) + it + scaled(kd_r, e - 2 * e1 + e2);
    end
    acc = clamp_sym(acc, out_lim_r);
    drive_last = acc;
    return acc[DriveW-1:0];
  endfunction

  // ------------------------------------------------------- drivers/monitor

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_req - 1;
      hold_req = 0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (drive_expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected drive result %0d", $signed(m_axis_tdata));
      end else begin
        drive_want = drive_expected_q.pop_front();
        if (m_axis_tdata !== drive_want) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports)
            $display("drive mismatch: expected %0d, got %0d",
                     $signed(drive_want), $signed(m_axis_tdata));
        end
      end
    end
  end

  task automatic send_request(input logic signed [SampleW-1:0] meas,
                              input logic signed [SampleW-1:0] sp,
                              input logic clr);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sp, meas};
    s_axis_tuser  <= clr;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    drive_expected_q.push_back(predict_drive(meas, sp, clr));
  endtask

  // lets the pipeline empty before any register write
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (drive_expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      pidpi_pkg::RegMode: mode_r    = data[0];
      pidpi_pkg::RegKp:   kp_r      = data[GainW-1:0];
      pidpi_pkg::RegKi:   ki_r      = data[GainW-1:0];
      pidpi_pkg::RegKd:   kd_r      = data[GainW-1:0];
      pidpi_pkg::RegOlim: out_lim_r = data[LimW-1:0];
      pidpi_pkg::RegIlim: int_lim_r = data[LimW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // unused upper bits carry junk; the block must drop them
  task automatic write_masked(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val,
                              input int unsigned w);
    logic [CfgDatW-1:0] m;
    m = (CfgDatW'(1) << w) - 1;
    write_reg(idx, (CfgDatW'($urandom) & ~m) | (val & m));
  endtask

  task automatic program_regs(input logic mode, input logic [GainW-1:0] kp,
                              input logic [GainW-1:0] ki, input logic [GainW-1:0] kd,
                              input logic [LimW-1:0] olim, input logic [LimW-1:0] ilim);
    write_masked(pidpi_pkg::RegMode, CfgDatW'(mode), 1);
    write_masked(pidpi_pkg::RegKp, CfgDatW'(kp), GainW);
    write_masked(pidpi_pkg::RegKi, CfgDatW'(ki), GainW);
    write_masked(pidpi_pkg::RegKd, CfgDatW'(kd), GainW);
    write_masked(pidpi_pkg::RegOlim, CfgDatW'(olim), LimW);
    write_masked(pidpi_pkg::RegIlim, CfgDatW'(ilim), LimW);
  endtask

  function automatic logic [GainW-1:0] rand_gain();
    logic [GainW-1:0] g;
    case ($urandom_range(3))
      0: g = GainW'($urandom);
      1: g = GainW'($urandom_range(1 << 18)) - GainW'(1 << 17);
      2: g = GainW'($urandom_range(1 << 13)) - GainW'(1 << 12);
      default: g = GainW'($urandom_range(1 << 16));
    endcase
    return g;
  endfunction

  function automatic logic [LimW-1:0] rand_limit();
    logic [LimW-1:0] l;
    case ($urandom_range(5))
      0: l = '0;
      1: l = LimMax;
      2: l = LimW'($urandom);
      default: l = LimW'($urandom_range(1 << 22));
    endcase
    return l;
  endfunction

  // ------------------------------------------------------------------ tests

  task automatic test_reset_state();
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh7FFF, 16'sh8000, 1'b0);
    send_request(16'sh1234, 16'shFEDC, 1'b1);
    settle();
  endtask

  task automatic test_spare_indexes();
    program_regs(pidpi_pkg::ModePositional, '0, '0, '0, LimMax, LimMax);
    write_reg(RegSpare0, '1);
    write_reg(RegSpare1, '1);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh0000, 16'sh7FFF, 1'b0);
    settle();
  endtask

  task automatic test_positional_extremes();
    program_regs(pidpi_pkg::ModePositional, GainMax, GainMax, GainMax, LimMax, LimMax);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh7FFF, 16'sh8000, 1'b0);
    send_request(16'sh0000, 16'sh0000, 1'b0);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh5555, 16'shAAAA, 1'b1);
    settle();
    program_regs(pidpi_pkg::ModePositional, GainMin, GainMin, GainMin, LimMax, 31'd100000);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh7FFF, 16'sh8000, 1'b0);
    send_request(16'shFFFF, 16'sh0001, 1'b0);
    settle();
  endtask

  task automatic test_incremental_extremes();
    program_regs(pidpi_pkg::ModeIncremental, GainMax, GainMax, GainMax, LimMax, '0);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh7FFF, 16'sh8000, 1'b0);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh0000, 16'sh0000, 1'b1);
    settle();
    program_regs(pidpi_pkg::ModeIncremental, GainMin, 24'h010000, GainMin, 31'd5000000,
                 LimMax);
    send_request(16'sh0100, 16'sh0000, 1'b0);
    send_request(16'sh0000, 16'sh0100, 1'b0);
    send_request(16'sh7FFF, 16'sh8000, 1'b0);
    settle();
  endtask

  task automatic test_zero_limits();
    program_regs(pidpi_pkg::ModePositional, GainMax, GainMax, GainMax, '0, LimMax);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh7FFF, 16'sh8000, 1'b0);
    settle();
    program_regs(pidpi_pkg::ModePositional, 24'h010000, GainMax, '0, LimMax, '0);
    send_request(16'sh8000, 16'sh7FFF, 1'b0);
    send_request(16'sh0010, 16'sh0000, 1'b0);
    settle();
  endtask

  task automatic random_setting(input int unsigned k);
    case (k)
      0: program_regs(pidpi_pkg::ModePositional, GainMax, GainMax, GainMax, LimMax, LimMax);
      1: program_regs(pidpi_pkg::ModeIncremental, GainMin, GainMin, GainMin, LimMax, LimMax);
      default: program_regs(1'($urandom), rand_gain(), rand_gain(), rand_gain(),
                            rand_limit(), rand_limit());
    endcase
  endtask

  task automatic random_burst(input int unsigned n);
    logic signed [SampleW-1:0] meas, sp;
    int unsigned r;
    for (int unsigned i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      sp = SampleW'($urandom);
      if (r < 45)
        meas = sp + SampleW'($urandom_range(512)) - SampleW'(256);
      else
        meas = SampleW'($urandom);
      send_request(meas, sp, r < 3);
    end
  endtask

  task automatic test_random_traffic();
    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 23; rcv_idle_pct = 63; end
        1: begin snd_idle_pct = 63; rcv_idle_pct = 23; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int unsigned k = 0; k < 4; k++) begin
        random_setting(k);
        random_burst(64);
        settle();
      end
    end
  endtask

  task automatic test_backpressure();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_setting(2);
    hold_req = 80;
    random_burst(40);
    settle();
  endtask

  initial begin
    mode_r     = pidpi_pkg::ModePositional;
    kp_r       = '0;
    ki_r       = '0;
    kd_r       = '0;
    out_lim_r  = '0;
    int_lim_r  = '0;
    err_last   = 0;
    err_older  = 0;
    integ_acc  = 0;
    drive_last = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_spare_indexes();
    test_positional_extremes();
    test_incremental_extremes();
    test_zero_limits();
    test_random_traffic();
    test_backpressure();

    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("pid_position_and_incremental regression: pass");
    else
      $display("pid_position_and_incremental regression: fail");
    $finish;
  end

endmodule

// ===== files.f =====
sv/pidpi_pkg.sv
sv/pid_position_and_incremental.sv
sim/tb.sv
